// ===== rtl/core/vtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpg_pkg
// Shared types and constants of the RGB565 test pattern generator: register
// map, pattern codes, bar palette and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpg_pkg;

    // Configuration port
    localparam int CFG_W = 12;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN      = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Pattern codes (any other code draws the grid)
    localparam int PAT_W = 2;
    localparam logic [PAT_W-1:0] PAT_BARS    = 2'd0;
    localparam logic [PAT_W-1:0] PAT_RAMP    = 2'd1;
    localparam logic [PAT_W-1:0] PAT_RESET   = 2'd0;

    // Pixel payload
    localparam int COLOR_W = 16;
    localparam int POS_W   = 11;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

    // Color bars
    localparam int BAR_COUNT = 7;
    localparam int BIDX_W    = 3;
    localparam logic [BIDX_W-1:0] BAR_LAST = 3'd6;
    localparam logic [CFG_W-1:0]  MIN_WIDTH = 12'd7;

    localparam logic [COLOR_W-1:0] BAR_PALETTE [BAR_COUNT] = '{
        16'hF800, 16'h07E0, 16'h001F, 16'hFFFF, 16'h07FF, 16'hF81F, 16'hFFE0
    };

    // Bar width = width / 7 by reciprocal multiply: ceil(2^14 / 7), exact below 5461
    localparam int BAR_RECIP_W     = 12;
    localparam int BAR_PROD_W      = CFG_W + BAR_RECIP_W;
    localparam int BAR_RECIP_SHIFT = 14;
    localparam logic [BAR_RECIP_W-1:0] BAR_RECIP = 12'd2341;

    // Grey ramp
    localparam int GRAY_W = 8;
    localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

    // Shared divider: dividend is column * 255 at most
    localparam int DVW       = CFG_W + GRAY_W;
    localparam int DIV_CNT_W = $clog2(DVW);

    // Divisions run after reset and after every register write
    typedef enum logic [1:0] {
        DIV_STEP    = 2'd0,   // 255 / width
        DIV_BAR_IDX = 2'd1,   // column / bar width
        DIV_GRAY    = 2'd2    // column * 255 / width
    } div_op_t;

    typedef struct packed {
        logic    run;
        logic    div_start;
        div_op_t div_op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/vtpg_div.sv =====
// ----------------------------------------------------------------------------
// vtpg_div
// Restoring radix-2 divider, one quotient bit per clock. A start reloads it
// and cancels any division still running.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpg_div
    import vtpg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVW-1:0]   dividend,
    input  wire logic [CFG_W-1:0] divisor,
    output logic                  done,
    output logic [DVW-1:0]        quotient,
    output logic [CFG_W-1:0]      remainder
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DVW - 1);

    logic [DVW-1:0]       quo_reg, quo_next;
    logic [CFG_W-1:0]     rem_reg, rem_next;
    logic [CFG_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [CFG_W:0] r_shift;
    logic [CFG_W:0] r_diff;
    logic           fits;

    // One trial subtraction per cycle
    always_comb
    begin
        r_shift  = {rem_reg, quo_reg[DVW-1]};
        fits     = r_shift >= {1'b0, dsr_reg};
        r_diff   = fits ? (r_shift - {1'b0, dsr_reg}) : r_shift;
        rem_next = r_diff[CFG_W-1:0];
        quo_next = {quo_reg[DVW-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_LAST;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // A stale done never reaches a freshly started division
    assign done      = done_reg && !start;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vtpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// vtpg_ctrl
// Sequencer: after reset and after each register write it runs the three
// setup divisions on the shared divider, then lets pixels flow.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpg_ctrl
    import vtpg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_ISSUE,
        ST_WAIT,
        ST_RUN
    } state_t;

    state_t  state_reg;
    div_op_t op_reg;
    logic    start_reg;
    logic    run_reg;

    // State and registered commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ISSUE;
            op_reg    <= DIV_STEP;
            start_reg <= 1'b0;
            run_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            // new geometry: redo all setup divisions
            state_reg <= ST_ISSUE;
            op_reg    <= DIV_STEP;
            start_reg <= 1'b0;
            run_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_ISSUE:
                begin
                    start_reg <= 1'b1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    start_reg <= 1'b0;
                    if (status.div_done)
                    begin
                        unique case (op_reg)
                            DIV_STEP:    op_reg <= DIV_BAR_IDX;
                            DIV_BAR_IDX: op_reg <= DIV_GRAY;
                            DIV_GRAY:    op_reg <= DIV_GRAY;
                            default:     op_reg <= DIV_STEP;
                        endcase
                        if (op_reg == DIV_GRAY)
                        begin
                            state_reg <= ST_RUN;
                            run_reg   <= 1'b1;
                        end
                        else
                            state_reg <= ST_ISSUE;
                    end
                end
                ST_RUN:
                begin
                    start_reg <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_ISSUE;
                    op_reg    <= DIV_STEP;
                    start_reg <= 1'b0;
                    run_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign cmd.run       = run_reg;
    assign cmd.div_start = start_reg;
    assign cmd.div_op    = op_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vtpg_datapath.sv =====
// ----------------------------------------------------------------------------
// vtpg_datapath
// Registers, raster counters, incremental bar/ramp/grid accumulators, the
// shared divider that seeds them, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpg_datapath
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int GRID_SPACING = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_cmd_t          cmd,
    output ctrl_status_t            status,
    input  wire logic               cfg_write,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COLOR_W-1:0]      pixel_color,
    output logic [POS_W-1:0]        pixel_column,
    output logic [POS_W-1:0]        pixel_row,
    output logic                    end_of_line,
    output logic                    end_of_frame
);

    // Counter widths; columns and rows never reach the 12-bit register limit
    localparam int CW_RAW = $clog2(MAX_WIDTH);
    localparam int CW     = (CW_RAW < CFG_W) ? CW_RAW : CFG_W;
    localparam int RW_RAW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW     = (RW_RAW < CFG_W) ? RW_RAW : CFG_W;
    localparam int GW     = $clog2(GRID_SPACING);
    localparam logic [GW-1:0] GRID_LAST = GW'(GRID_SPACING - 1);

    // Configuration registers
    logic [CFG_W-1:0] fw_reg;
    logic [CFG_W-1:0] fh_reg;
    logic [PAT_W-1:0] pat_reg;

    // Setup results
    logic [CFG_W-1:0]  bar_w_reg;
    logic [GRAY_W-1:0] q255_reg;
    logic [CFG_W-1:0]  r255_reg;

    // Raster state and accumulators tracking the stored column/row
    logic [CW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    logic [BIDX_W-1:0] bidx_reg;
    logic [CFG_W-1:0]  brem_reg;
    logic [GRAY_W-1:0] gq_reg;
    logic [CFG_W-1:0]  gr_reg;
    logic [GW-1:0]     gx_reg;
    logic [GW-1:0]     gy_reg;

    // Output register
    logic               out_valid_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [POS_W-1:0]   column_reg;
    logic [POS_W-1:0]   row_out_reg;
    logic               eol_reg;
    logic               eof_reg;

    // Divider hookup
    logic [DVW-1:0]   div_dvd;
    logic [CFG_W-1:0] div_dsr;
    logic             div_done;
    logic [DVW-1:0]   div_quot;
    logic [CFG_W-1:0] div_rem;

    logic in_fire;

    // Effective geometry
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    always_comb
    begin
        if (fw_reg < MIN_WIDTH)
            w_eff = MIN_WIDTH;
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff = CFG_W'(MAX_WIDTH);
        else
            w_eff = fw_reg;

        if (fh_reg == '0)
            h_eff = CFG_W'(1);
        else if (32'(fh_reg) > MAX_HEIGHT)
            h_eff = CFG_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    // Bar width from the effective width
    logic [BAR_PROD_W-1:0] bar_prod;
    logic [CFG_W-1:0]      bar_w_c;

    always_comb
    begin
        bar_prod = BAR_PROD_W'(w_eff) * BAR_PROD_W'(BAR_RECIP);
        bar_w_c  = CFG_W'(bar_prod >> BAR_RECIP_SHIFT);
    end

    // Handshake
    assign in_stall = !cmd.run || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    // Position of the pixel about to be emitted
    logic [CFG_W-1:0] col_ext;
    logic [CFG_W-1:0] row_ext;
    logic             col_over;
    logic             wrap_col;
    logic [CW-1:0]    x_sel;
    logic [CFG_W-1:0] x_ext;
    logic [CFG_W:0]   y_pre;
    logic [GW-1:0]    gy_pre;
    logic [GW-1:0]    gy_inc;
    logic [RW-1:0]    y_sel;
    logic [CFG_W-1:0] y_ext;
    logic [GW-1:0]    gy_sel;
    logic             eol_c;
    logic             eof_c;

    always_comb
    begin
        col_ext  = CFG_W'(col_reg);
        row_ext  = CFG_W'(row_reg);
        col_over = col_ext >= w_eff;
        wrap_col = restart || col_over;
        x_sel    = wrap_col ? '0 : col_reg;
        x_ext    = CFG_W'(x_sel);

        gy_inc = (gy_reg == GRID_LAST) ? '0 : gy_reg + 1'b1;
        if (restart)
        begin
            y_pre  = '0;
            gy_pre = '0;
        end
        else if (col_over)
        begin
            y_pre  = {1'b0, row_ext} + 1'b1;
            gy_pre = gy_inc;
        end
        else
        begin
            y_pre  = {1'b0, row_ext};
            gy_pre = gy_reg;
        end

        if (y_pre >= {1'b0, h_eff})
        begin
            y_sel  = '0;
            gy_sel = '0;
        end
        else
        begin
            y_sel  = RW'(y_pre);
            gy_sel = gy_pre;
        end
        y_ext = CFG_W'(y_sel);

        eol_c = x_ext == (w_eff - 1'b1);
        eof_c = eol_c && (y_ext == (h_eff - 1'b1));
    end

    // Accumulators for the emitted pixel and their advance by one column
    logic [BIDX_W-1:0] bidx_s,  bidx_next;
    logic [CFG_W-1:0]  brem_s,  brem_next;
    logic [GRAY_W-1:0] gq_s,    gq_next;
    logic [CFG_W-1:0]  gr_s,    gr_next;
    logic [GW-1:0]     gx_s,    gx_next;
    logic [CFG_W:0]    gr_sum;
    logic              gr_carry;

    always_comb
    begin
        bidx_s = wrap_col ? '0 : bidx_reg;
        brem_s = wrap_col ? '0 : brem_reg;
        gq_s   = wrap_col ? '0 : gq_reg;
        gr_s   = wrap_col ? '0 : gr_reg;
        gx_s   = wrap_col ? '0 : gx_reg;

        // bar index saturates on the last bar
        if (bidx_s == BAR_LAST)
        begin
            bidx_next = bidx_s;
            brem_next = brem_s;
        end
        else if ((brem_s + 1'b1) == bar_w_reg)
        begin
            bidx_next = bidx_s + 1'b1;
            brem_next = '0;
        end
        else
        begin
            bidx_next = bidx_s;
            brem_next = brem_s + 1'b1;
        end

        // ramp: add 255/W with remainder carry
        gr_sum   = {1'b0, gr_s} + {1'b0, r255_reg};
        gr_carry = gr_sum >= {1'b0, w_eff};
        gr_next  = gr_carry ? CFG_W'(gr_sum - {1'b0, w_eff}) : CFG_W'(gr_sum);
        gq_next  = gq_s + q255_reg + GRAY_W'(gr_carry);

        gx_next = (gx_s == GRID_LAST) ? '0 : gx_s + 1'b1;
    end

    // Pixel color
    logic [COLOR_W-1:0] color_c;

    always_comb
    begin
        case (pat_reg)
            PAT_BARS: color_c = BAR_PALETTE[bidx_s];
            PAT_RAMP: color_c = {gq_s[7:3], gq_s[7:2], gq_s[7:3]};
            default:
            begin
                if (gx_s == '0 || gy_sel == '0)
                    color_c = COLOR_WHITE;
                else
                    color_c = COLOR_BLACK;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FRAME_WIDTH_RESET;
            fh_reg  <= FRAME_HEIGHT_RESET;
            pat_reg <= PAT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg  <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg  <= cfg_data;
                REG_PATTERN:      pat_reg <= cfg_data[PAT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Divider operand select
    always_comb
    begin
        unique case (cmd.div_op)
            DIV_STEP:
            begin
                div_dvd = DVW'(GRAY_MAX);
                div_dsr = w_eff;
            end
            DIV_BAR_IDX:
            begin
                div_dvd = DVW'(col_ext);
                div_dsr = bar_w_reg;
            end
            DIV_GRAY:
            begin
                div_dvd = {col_ext, {GRAY_W{1'b0}}} - DVW'(col_ext);
                div_dsr = w_eff;
            end
            default:
            begin
                div_dvd = '0;
                div_dsr = w_eff;
            end
        endcase
    end

    vtpg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign status.div_done = div_done;

    // Setup results
    always_ff @(posedge clk)
    begin
        bar_w_reg <= bar_w_c;
        if (div_done)
        begin
            case (cmd.div_op)
                DIV_STEP:
                begin
                    q255_reg <= div_quot[GRAY_W-1:0];
                    r255_reg <= div_rem;
                end
                default:   ;
            endcase
        end
    end

    // Raster counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            bidx_reg <= '0;
            brem_reg <= '0;
            gq_reg   <= '0;
            gr_reg   <= '0;
            gx_reg   <= '0;
            gy_reg   <= '0;
        end
        else if (in_fire)
        begin
            if (eol_c)
            begin
                col_reg  <= '0;
                bidx_reg <= '0;
                brem_reg <= '0;
                gq_reg   <= '0;
                gr_reg   <= '0;
                gx_reg   <= '0;
                if (eof_c)
                begin
                    row_reg <= '0;
                    gy_reg  <= '0;
                end
                else
                begin
                    row_reg <= y_sel + 1'b1;
                    gy_reg  <= (gy_sel == GRID_LAST) ? '0 : gy_sel + 1'b1;
                end
            end
            else
            begin
                col_reg  <= x_sel + 1'b1;
                bidx_reg <= bidx_next;
                brem_reg <= brem_next;
                gq_reg   <= gq_next;
                gr_reg   <= gr_next;
                gx_reg   <= gx_next;
                row_reg  <= y_sel;
                gy_reg   <= gy_sel;
            end
        end
        else if (div_done)
        begin
            // seed the accumulators for the stored column
            case (cmd.div_op)
                DIV_BAR_IDX:
                begin
                    bidx_reg <= (div_quot >= DVW'(BAR_LAST)) ? BAR_LAST
                                                             : div_quot[BIDX_W-1:0];
                    brem_reg <= div_rem;
                end
                DIV_GRAY:
                begin
                    gq_reg <= div_quot[GRAY_W-1:0];
                    gr_reg <= div_rem;
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            color_reg   <= color_c;
            column_reg  <= x_ext[POS_W-1:0];
            row_out_reg <= y_ext[POS_W-1:0];
            eol_reg     <= eol_c;
            eof_reg     <= eof_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_color  = color_reg;
    assign pixel_column = column_reg;
    assign pixel_row    = row_out_reg;
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

    // Checks
    a_eof_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && eof_reg |-> eol_reg)
        else $error("end of frame without end of line");

    a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg <= BAR_LAST)
        else $error("bar index past last bar");

    a_ramp_rem: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |-> gr_reg < w_eff)
        else $error("ramp remainder not below width");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !wrap_col && !eol_c |=> col_reg == $past(col_reg) + 1'b1)
        else $error("column did not advance by one");

endmodule

`default_nettype wire

// ===== rtl/core/video_test_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// video_test_pattern_generator_core
// RGB565 test pattern source: color bars, grey ramp or grid, raster order.
// ----------------------------------------------------------------------------
// One input beat produces one pixel beat. While running, the core takes a
// beat every clock and keeps doing so as long as the output side drains; an
// output register decouples the two channels. Bars, ramp and grid come from
// incremental accumulators, so no per-pixel division is needed; the bar width
// is a reciprocal multiply of the width. After reset and after every register
// write the core seeds the accumulators with three divisions on a shared
// one-bit-per-clock divider; in_stall stays high until the third one is done.
`default_nettype none

module video_test_pattern_generator_core
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int GRID_SPACING = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               restart,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COLOR_W-1:0]      pixel_color,
    output logic [POS_W-1:0]        pixel_column,
    output logic [POS_W-1:0]        pixel_row,
    output logic                    end_of_line,
    output logic                    end_of_frame
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // Sequencer
    vtpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    vtpg_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .GRID_SPACING (GRID_SPACING)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_color  (pixel_color),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

endmodule

`default_nettype wire
